>>> hdl/alist_pkg.sv
package alist_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned STAT_W       = 3;
  localparam int unsigned IDX_OUT_W    = 4;
  localparam int unsigned CNT_OUT_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_BOUNDS    = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // Broadcast from the controller to every cell of the ring.
  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

>>> hdl/array_list_engine_top.sv
// Ordered list of up to DEPTH signed 32-bit entries held in a ring of cells.
// A command is taken when start is high and busy is low; each result is shown
// for one cycle with done_o high, in the cycle after the command (insert, delete,
// failed commands, search or dump on an empty list) and cannot be held off.
// Insert and delete shift all cells at once, so a new command may follow in the
// next cycle. Search and dump rotate the ring one full turn through cell 0,
// during which busy is high: a dump shows the entries in order from entry 0,
// and the last entry of a full list comes out once busy has dropped, while a
// search reports in the cycle right after the turn.
module array_list_engine_top #(
  parameter int unsigned DEPTH = alist_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [alist_pkg::CMD_W-1:0]         command_i,
  input  logic [alist_pkg::POS_W-1:0]         position_i,
  input  logic signed [alist_pkg::DATA_W-1:0] value_i,
  output logic                                done_o,
  output logic [alist_pkg::STAT_W-1:0]        status_o,
  output logic signed [alist_pkg::DATA_W-1:0] data_out_o,
  output logic [alist_pkg::IDX_OUT_W-1:0]     found_index_o,
  output logic [alist_pkg::CNT_OUT_W-1:0]     count_o,
  output logic                                last_of_run_o
);
  import alist_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > POS_W) ? CntW : POS_W;

  logic [DATA_W-1:0] entry_w [DEPTH];
  cell_cmd_t         cell_cmd;
  logic [CmpW-1:0]   cell_pos;
  logic [DATA_W-1:0] data_out_w;

  alist_ctrl #(
    .DEPTH (DEPTH),
    .CmpW  (CmpW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .entries_i     (entry_w),
    .cell_cmd_o    (cell_cmd),
    .cell_pos_o    (cell_pos),
    .done_o        (done_o),
    .status_o      (status_o),
    .data_out_o    (data_out_w),
    .found_index_o (found_index_o),
    .count_o       (count_o),
    .last_of_run_o (last_of_run_o)
  );

  assign data_out_o = data_out_w;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    alist_cell #(
      .DEPTH (DEPTH),
      .IDX   (i),
      .CmpW  (CmpW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cell_cmd),
      .pos_i   (cell_pos),
      .left_i  (entry_w[(i + DEPTH - 1) % DEPTH]),
      .right_i (entry_w[(i + 1) % DEPTH]),
      .entry_o (entry_w[i])
    );
  end

endmodule

>>> hdl/alist_cell.sv
module alist_cell #(
  parameter int unsigned DEPTH = alist_pkg::DepthDefault,
  parameter int unsigned IDX   = 0,
  parameter int unsigned CmpW  = alist_pkg::POS_W
) (
  input  logic                         clk_i,
  input  alist_pkg::cell_cmd_t         cmd_i,
  input  logic [CmpW-1:0]              pos_i,
  input  logic [alist_pkg::DATA_W-1:0] left_i,
  input  logic [alist_pkg::DATA_W-1:0] right_i,
  output logic [alist_pkg::DATA_W-1:0] entry_o
);
  import alist_pkg::*;

  localparam logic [CmpW-1:0] MyIdx = CmpW'(IDX % DEPTH);

  logic [DATA_W-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      CELL_HOLD: begin
        entry_d = entry_q;
      end
      CELL_INSERT: begin
        if (MyIdx == pos_i) begin
          entry_d = cmd_i.value;
        end else if (MyIdx > pos_i) begin
          entry_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= pos_i) begin
          entry_d = right_i;
        end
      end
      CELL_ROTATE: begin
        entry_d = right_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> hdl/alist_ctrl.sv
module alist_ctrl #(
  parameter int unsigned DEPTH = alist_pkg::DepthDefault,
  parameter int unsigned CmpW  = alist_pkg::POS_W
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [alist_pkg::CMD_W-1:0]     command_i,
  input  logic [alist_pkg::POS_W-1:0]     position_i,
  input  logic [alist_pkg::DATA_W-1:0]    value_i,
  input  logic [alist_pkg::DATA_W-1:0]    entries_i [DEPTH],
  output alist_pkg::cell_cmd_t            cell_cmd_o,
  output logic [CmpW-1:0]                 cell_pos_o,
  output logic                            done_o,
  output logic [alist_pkg::STAT_W-1:0]    status_o,
  output logic [alist_pkg::DATA_W-1:0]    data_out_o,
  output logic [alist_pkg::IDX_OUT_W-1:0] found_index_o,
  output logic [alist_pkg::CNT_OUT_W-1:0] count_o,
  output logic                            last_of_run_o
);
  import alist_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   step_q, step_d;
  logic              scan_dump_q, scan_dump_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   hit_idx_q, hit_idx_d;
  logic [DATA_W-1:0] key_q, key_d;

  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic [DATA_W-1:0]    data_q, data_d;
  logic [IDX_OUT_W-1:0] fidx_q, fidx_d;
  logic                 last_q, last_d;

  cmd_e            cmd;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic [CntW-1:0] step_ext;
  logic            step_last;
  logic            in_range;
  logic            hit;
  logic            need_scan;

  assign cmd       = cmd_e'(command_i);
  assign pos_ext   = CmpW'(position_i);
  assign cnt_ext   = CmpW'(count_q);
  assign step_ext  = CntW'(step_q);
  assign step_last = (step_q == IdxW'(DEPTH - 1));
  assign in_range  = (step_ext < count_q);
  // entries_i[0] holds original entry step_q while the ring rotates
  assign hit       = in_range && !found_q && (entries_i[0] == key_q);
  assign need_scan = ((cmd == CMD_SEARCH) || (cmd == CMD_DUMP)) && (count_q != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start && need_scan) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step_last) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cell_cmd_o.op    = CELL_HOLD;
    cell_cmd_o.value = value_i;
    cell_pos_o       = pos_ext;
    count_d          = count_q;
    step_d           = step_q;
    scan_dump_d      = scan_dump_q;
    found_d          = found_q;
    hit_idx_d        = hit_idx_q;
    key_d            = key_q;
    done_d           = 1'b0;
    status_d         = STAT_OK;
    data_d           = '0;
    fidx_d           = '0;
    last_d           = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        step_d  = '0;
        found_d = 1'b0;
        if (start) begin
          scan_dump_d = (cmd == CMD_DUMP);
          key_d       = value_i;
          unique case (cmd)
            CMD_INSERT: begin
              done_d = 1'b1;
              last_d = 1'b1;
              if (count_q == CntW'(DEPTH)) begin
                status_d = STAT_FULL;
              end else if (pos_ext > cnt_ext) begin
                status_d = STAT_BOUNDS;
              end else begin
                cell_cmd_o.op = CELL_INSERT;
                count_d       = CntW'(count_q + 1'b1);
              end
            end
            CMD_DELETE: begin
              done_d = 1'b1;
              last_d = 1'b1;
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                status_d = STAT_BOUNDS;
              end else begin
                cell_cmd_o.op = CELL_DELETE;
                count_d       = CntW'(count_q - 1'b1);
                data_d        = entries_i[pos_ext[IdxW-1:0]];
              end
            end
            CMD_SEARCH: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                last_d   = 1'b1;
                status_d = STAT_NOT_FOUND;
              end
            end
            CMD_DUMP: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                last_d   = 1'b1;
                status_d = STAT_EMPTY;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        // full turn of the ring, DEPTH steps, so order is restored at the end
        cell_cmd_o.op = CELL_ROTATE;
        step_d        = IdxW'(step_q + 1'b1);
        if (hit) begin
          found_d   = 1'b1;
          hit_idx_d = step_q;
        end
        if (scan_dump_q) begin
          if (in_range) begin
            done_d = 1'b1;
            data_d = entries_i[0];
            fidx_d = IDX_OUT_W'(step_q);
            last_d = (step_ext == CntW'(count_q - 1'b1));
          end
        end else if (step_last) begin
          done_d = 1'b1;
          last_d = 1'b1;
          if (found_q) begin
            fidx_d = IDX_OUT_W'(hit_idx_q);
          end else if (hit) begin
            fidx_d = IDX_OUT_W'(step_q);
          end else begin
            status_d = STAT_NOT_FOUND;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      scan_dump_q <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      scan_dump_q <= scan_dump_d;
      found_q     <= found_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    key_q     <= key_d;
    status_q  <= status_d;
    data_q    <= data_d;
    fidx_q    <= fidx_d;
    last_q    <= last_d;
  end

  assign busy          = (state_q == ST_SCAN);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign data_out_o    = data_q;
  assign found_index_o = fidx_q;
  assign count_o       = CNT_OUT_W'(count_q);
  assign last_of_run_o = last_q;

endmodule

>>> tb/tb_array_list_engine_top.sv
module tb_array_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import alist_pkg::*;

  localparam int unsigned ListDepth = DepthDefault;
  localparam int RandItems = 92;

  typedef struct {
    status_e            status;
    logic signed [31:0] data;
    logic [3:0]         idx;
    logic [4:0]         cnt;
    logic               last;
  } list_result_t;

  typedef struct {
    cmd_e               cmd;
    logic [4:0]         pos;
    logic signed [31:0] val;
    bit                 typed;
    status_e            status;
    logic signed [31:0] data;
    logic [3:0]         idx;
    logic [4:0]         cnt;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] command_i = '0;
  logic [POS_W-1:0] position_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic done_o;
  logic [STAT_W-1:0] status_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic [IDX_OUT_W-1:0] found_index_o;
  logic [CNT_OUT_W-1:0] count_o;
  logic last_of_run_o;

  // shadow copy of the list
  logic signed [31:0] list_mem [ListDepth];
  int list_cnt = 0;
  list_result_t cmd_results [ListDepth];
  list_result_t pending_results_q[$];
  dir_row_t directed_rows[$];

  int errors = 0;
  int cmds_sent = 0;
  int dumps_sent = 0;
  int results_checked = 0;
  int full_hits = 0;
  int empty_hits = 0;
  bit no_idle = 1'b0;

  array_list_engine_top #(
    .DEPTH(ListDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .found_index_o(found_index_o),
    .count_o      (count_o),
    .last_of_run_o(last_of_run_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic list_result_t mk_result(status_e s, logic signed [31:0] d,
                                             logic [3:0] ix, logic lst);
    list_result_t r;
    r.status = s;
    r.data   = d;
    r.idx    = ix;
    r.cnt    = 5'(list_cnt);
    r.last   = lst;
    return r;
  endfunction

  // Updates the shadow list and fills cmd_results; returns the result count.
  function automatic int apply_list_cmd(cmd_e c, logic [4:0] p, logic signed [31:0] v);
    int n;
    bit hit;
    logic signed [31:0] removed;
    n = 1;
    hit = 1'b0;
    case (c)
      CMD_INSERT: begin
        if (list_cnt >= ListDepth) begin
          cmd_results[0] = mk_result(STAT_FULL, 0, 0, 1'b1);
        end else if (p > list_cnt) begin
          cmd_results[0] = mk_result(STAT_BOUNDS, 0, 0, 1'b1);
        end else begin
          for (int i = list_cnt; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = v;
          list_cnt++;
          if (list_cnt == ListDepth) full_hits++;
          cmd_results[0] = mk_result(STAT_OK, 0, 0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (list_cnt == 0) begin
          cmd_results[0] = mk_result(STAT_EMPTY, 0, 0, 1'b1);
        end else if (p >= list_cnt) begin
          cmd_results[0] = mk_result(STAT_BOUNDS, 0, 0, 1'b1);
        end else begin
          removed = list_mem[p];
          for (int i = p; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
          list_cnt--;
          if (list_cnt == 0) empty_hits++;
          cmd_results[0] = mk_result(STAT_OK, removed, 0, 1'b1);
        end
      end
      CMD_SEARCH: begin
        cmd_results[0] = mk_result(STAT_NOT_FOUND, 0, 0, 1'b1);
        for (int i = 0; i < list_cnt; i++) begin
          if (!hit && list_mem[i] == v) begin
            hit = 1'b1;
            cmd_results[0] = mk_result(STAT_OK, 0, 4'(i), 1'b1);
          end
        end
      end
      default: begin
        if (list_cnt == 0) begin
          cmd_results[0] = mk_result(STAT_EMPTY, 0, 0, 1'b1);
        end else begin
          n = list_cnt;
          for (int i = 0; i < list_cnt; i++)
            cmd_results[i] = mk_result(STAT_OK, list_mem[i], 4'(i), i == list_cnt - 1);
        end
      end
    endcase
    return n;
  endfunction

  // One transaction: optional idle gap, then hold start until busy is low.
  task automatic issue_cmd(cmd_e c, logic [4:0] p, logic signed [31:0] v,
                           bit typed, list_result_t typed_res);
    int gap;
    int n;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start      <= 1'b0;
      command_i  <= CMD_W'($urandom_range(0, 3));
      position_i <= POS_W'($urandom_range(0, 31));
      value_i    <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= c;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (busy);
    n = apply_list_cmd(c, p, v);
    cmds_sent++;
    if (c == CMD_DUMP) dumps_sent++;
    if (typed) begin
      pending_results_q.push_back(typed_res);
    end else begin
      for (int i = 0; i < n; i++) pending_results_q.push_back(cmd_results[i]);
    end
  endtask

  function automatic dir_row_t row(cmd_e c, logic [4:0] p, logic signed [31:0] v,
                                   bit typed = 1'b0, status_e s = STAT_OK,
                                   logic signed [31:0] d = 0, logic [3:0] ix = 0,
                                   logic [4:0] ct = 0);
    dir_row_t r;
    r.cmd = c;
    r.pos = p;
    r.val = v;
    r.typed = typed;
    r.status = s;
    r.data = d;
    r.idx = ix;
    r.cnt = ct;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_value();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 32'sh8000_0000;
    if (k == 1) return 32'sh7fff_ffff;
    if (k < 6) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d data %0h",
                 $time, status_o, data_out_o);
        errors++;
      end else begin
        exp_r = pending_results_q.pop_front();
        check_field("status", 32'(exp_r.status), 32'(status_o));
        check_field("data_out", exp_r.data, data_out_o);
        check_field("found_index", 32'(exp_r.idx), 32'(found_index_o));
        check_field("count", 32'(exp_r.cnt), 32'(count_o));
        check_field("last_of_run", 32'(exp_r.last), 32'(last_of_run_o));
        results_checked++;
      end
    end
  end

  initial begin
    list_result_t tr;
    dir_row_t dr;
    int fill_cnt;
    int goal;
    int roll;
    cmd_e c;
    logic [4:0] p;
    logic signed [31:0] v;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-list errors, extremes, bounds, fill to capacity
    directed_rows.push_back(row(CMD_DUMP,   5'd0,  0, 1, STAT_EMPTY, 0, 0, 5'd0));
    directed_rows.push_back(row(CMD_DELETE, 5'd31, 0, 1, STAT_EMPTY, 0, 0, 5'd0));
    directed_rows.push_back(row(CMD_SEARCH, 5'd0,  0, 1, STAT_NOT_FOUND, 0, 0, 5'd0));
    directed_rows.push_back(row(CMD_INSERT, 5'd1,  5, 1, STAT_BOUNDS, 0, 0, 5'd0));
    directed_rows.push_back(row(CMD_INSERT, 5'd0,  32'sh8000_0000, 1, STAT_OK, 0, 0, 5'd1));
    directed_rows.push_back(row(CMD_INSERT, 5'd1,  32'sh7fff_ffff, 1, STAT_OK, 0, 0, 5'd2));
    directed_rows.push_back(row(CMD_INSERT, 5'd0,  -1, 1, STAT_OK, 0, 0, 5'd3));
    directed_rows.push_back(row(CMD_INSERT, 5'd31, 9, 1, STAT_BOUNDS, 0, 0, 5'd3));
    directed_rows.push_back(row(CMD_SEARCH, 5'd0,  32'sh7fff_ffff, 1, STAT_OK, 0, 4'd2, 5'd3));
    directed_rows.push_back(row(CMD_SEARCH, 5'd31, 0, 1, STAT_NOT_FOUND, 0, 0, 5'd3));
    directed_rows.push_back(row(CMD_DUMP,   5'd0,  0));
    fill_cnt = 3;
    for (int k = 0; k < ListDepth - 3; k++) begin
      p = (k % 3 == 0) ? 5'd0 : (k % 3 == 1) ? 5'(fill_cnt) : 5'(fill_cnt / 2);
      directed_rows.push_back(row(CMD_INSERT, p, {k[3:0], 28'h5a5_a5a5}));
      fill_cnt++;
    end
    // fullness wins over a bad position
    directed_rows.push_back(row(CMD_INSERT, 5'd17, 1, 1, STAT_FULL, 0, 0, 5'd16));
    directed_rows.push_back(row(CMD_DUMP,   5'd0,  0));
    directed_rows.push_back(row(CMD_DELETE, 5'd16, 0, 1, STAT_BOUNDS, 0, 0, 5'd16));
    directed_rows.push_back(row(CMD_DELETE, 5'd0,  0));

    foreach (directed_rows[i]) begin
      dr = directed_rows[i];
      tr = '{dr.status, dr.data, dr.idx, dr.cnt, 1'b1};
      if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
      issue_cmd(dr.cmd, dr.pos, dr.val, dr.typed, tr);
    end

    // random: drift the fill level toward a moving goal so both ends get hit
    goal = 0;
    for (int n = 0; n < RandItems; n++) begin
      if (list_cnt == goal) begin
        roll = $urandom_range(0, 3);
        goal = (roll == 0) ? 0 : (roll == 1) ? ListDepth : $urandom_range(0, ListDepth);
      end
      if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
      roll = $urandom_range(0, 99);
      if (roll < 8) c = CMD_DUMP;
      else if (roll < 25) c = CMD_SEARCH;
      else if (list_cnt < goal) c = (roll < 82) ? CMD_INSERT : CMD_DELETE;
      else if (list_cnt > goal) c = (roll < 82) ? CMD_DELETE : CMD_INSERT;
      else c = roll[0] ? CMD_INSERT : CMD_DELETE;

      if ($urandom_range(0, 9) == 0) p = 5'($urandom_range(0, 31));
      else if (c == CMD_INSERT) p = 5'($urandom_range(0, list_cnt));
      else if (c == CMD_DELETE && list_cnt > 0) p = 5'($urandom_range(0, list_cnt - 1));
      else p = 5'($urandom_range(0, 31));

      if (c == CMD_SEARCH && list_cnt > 0 && $urandom_range(0, 9) < 6)
        v = list_mem[$urandom_range(0, list_cnt - 1)];
      else
        v = rand_value();
      issue_cmd(c, p, v, 1'b0, tr);
    end
    start <= 1'b0;

    while (pending_results_q.size() != 0) @(posedge clk_i);
    repeat (ListDepth + 8) @(posedge clk_i);

    $display("Ran %0d commands (%0d dumps), checked %0d results.",
             cmds_sent, dumps_sent, results_checked);
    $display("List reached capacity %0d times and was emptied %0d times.",
             full_hits, empty_hits);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("Timeout with %0d results outstanding", pending_results_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> array_list_engine_top.f
hdl/alist_pkg.sv
hdl/alist_cell.sv
hdl/alist_ctrl.sv
hdl/array_list_engine_top.sv
tb/tb_array_list_engine_top.sv
